@@ rtl/srtf_pkg.sv @@
// ----------------------------------------------------------------------------
// srtf_pkg
// shared types and constants of the shortest-remaining-time-first scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package srtf_pkg;

   localparam int unsigned TIME_W = 16;
   localparam int unsigned CLK_W  = 32;
   localparam int unsigned SLOT_W = 4;

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_TICK  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;
   localparam logic [1:0] KIND_NONE  = 2'd3;

   typedef struct packed {
      logic [1:0]        kind;
      logic [TIME_W-1:0] arrival_time;
      logic [TIME_W-1:0] burst_length;
   } req_type;

   typedef struct packed {
      logic [CLK_W-1:0]  slot_end_time;
      logic [SLOT_W-1:0] chosen_slot;
      logic              idle;
      logic              finished;
      logic [CLK_W-1:0]  turnaround;
      logic [CLK_W-1:0]  waiting;
      logic              all_done;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_TICK,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
   } cmd_type;

   typedef struct packed {
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      logic [TIME_W-1:0] remaining;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

@@ rtl/srtf_ram.sv @@
// ----------------------------------------------------------------------------
// srtf_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module srtf_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/srtf_front.sv @@
// ----------------------------------------------------------------------------
// srtf_front
// accepts request items, decodes them into commands, queues all but kind none
// ----------------------------------------------------------------------------
`default_nettype none

module srtf_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire srtf_pkg::req_type req_item,
   output logic                  cmd_valid,
   input  wire logic             cmd_ready,
   output srtf_pkg::cmd_type     cmd
);

   srtf_pkg::cmd_type q_ff [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        cnt_ff;
   logic [1:0]        cnt_in;
   logic              keep;
   logic              push;
   logic              pop;
   srtf_pkg::cmd_type dec;

   // decode
   always_comb begin
      keep        = 1'b1;
      dec.arrival = req_item.arrival_time;
      dec.burst   = (req_item.burst_length == '0) ? srtf_pkg::TIME_W'(1)
                                                  : req_item.burst_length;
      dec.op      = srtf_pkg::OP_LOAD;
      unique case (req_item.kind)
         srtf_pkg::KIND_LOAD:  dec.op = srtf_pkg::OP_LOAD;
         srtf_pkg::KIND_TICK:  dec.op = srtf_pkg::OP_TICK;
         srtf_pkg::KIND_CLEAR: dec.op = srtf_pkg::OP_CLEAR;
         default:              keep   = 1'b0;
      endcase
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready && keep;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

`default_nettype wire

@@ rtl/srtf_back.sv @@
// ----------------------------------------------------------------------------
// srtf_back
// executes commands: table loads, clears and scheduling ticks
// ----------------------------------------------------------------------------
`default_nettype none

module srtf_back #(
   parameter int unsigned MAX_PROCS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   output logic                   cmd_ready,
   input  wire srtf_pkg::cmd_type cmd,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output srtf_pkg::rsp_type      rsp_item
);

   localparam int unsigned IW = $clog2(MAX_PROCS);
   localparam int unsigned CW = $clog2(MAX_PROCS + 1);
   localparam int unsigned TW = srtf_pkg::TIME_W;
   localparam int unsigned KW = srtf_pkg::CLK_W;

   srtf_pkg::state_type state_ff;
   srtf_pkg::state_type state_in;

   logic [KW-1:0] time_ff;
   logic [KW-1:0] time_in;
   logic [CW-1:0] loaded_ff;
   logic [CW-1:0] loaded_in;
   logic [CW-1:0] fincnt_ff;
   logic [CW-1:0] fincnt_in;
   logic [CW-1:0] rd_idx_ff;
   logic [CW-1:0] rd_idx_in;
   logic          cmp_vld_ff;
   logic          cmp_vld_in;
   logic [IW-1:0] cmp_idx_ff;
   logic [IW-1:0] cmp_idx_in;
   logic          found_ff;
   logic          found_in;
   logic [IW-1:0] best_idx_ff;
   logic [IW-1:0] best_idx_in;
   logic [TW-1:0] best_arr_ff;
   logic [TW-1:0] best_arr_in;
   logic [TW-1:0] best_bur_ff;
   logic [TW-1:0] best_bur_in;
   logic [TW-1:0] best_rem_ff;
   logic [TW-1:0] best_rem_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   srtf_pkg::rsp_type rsp_ff;
   srtf_pkg::rsp_type rsp_in;

   logic                issue;
   logic                scan_end;
   logic                out_free;
   logic                better;
   logic [TW-1:0]       new_rem;
   logic                fin;
   logic [KW-1:0]       turn;
   logic [CW-1:0]       fincnt_next;
   logic                wr_en;
   logic [IW-1:0]       wr_addr;
   srtf_pkg::entry_type wr_data;
   srtf_pkg::entry_type rd_data;

   srtf_ram #(
      .WIDTH ($bits(srtf_pkg::entry_type)),
      .DEPTH (MAX_PROCS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_idx_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   assign issue    = (rd_idx_ff < loaded_ff);
   assign scan_end = !issue && !cmp_vld_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign better   = (KW'(rd_data.arrival) <= time_ff) && (rd_data.remaining != '0) &&
                     (!found_ff || (rd_data.remaining < best_rem_ff) ||
                      ((rd_data.remaining == best_rem_ff) && (rd_data.arrival < best_arr_ff)));
   assign new_rem  = best_rem_ff - TW'(1);
   assign fin      = found_ff && (new_rem == '0);
   assign turn     = time_ff - KW'(best_arr_ff);
   assign fincnt_next = fincnt_ff + CW'(fin);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srtf_pkg::ST_IDLE: begin
            if (cmd_valid && (cmd.op == srtf_pkg::OP_TICK)) begin
               state_in = srtf_pkg::ST_SCAN;
            end
         end
         srtf_pkg::ST_SCAN: begin
            if (scan_end) begin
               state_in = srtf_pkg::ST_DONE;
            end
         end
         srtf_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = srtf_pkg::ST_IDLE;
            end
         end
         default: state_in = srtf_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      cmd_ready    = 1'b0;
      time_in      = time_ff;
      loaded_in    = loaded_ff;
      fincnt_in    = fincnt_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = rd_idx_ff[IW-1:0];
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_arr_in  = best_arr_ff;
      best_bur_in  = best_bur_ff;
      best_rem_in  = best_rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = loaded_ff[IW-1:0];
      wr_data.arrival   = cmd.arrival;
      wr_data.burst     = cmd.burst;
      wr_data.remaining = cmd.burst;
      unique case (state_ff)
         srtf_pkg::ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               unique case (cmd.op)
                  srtf_pkg::OP_LOAD: begin
                     if (loaded_ff < CW'(MAX_PROCS)) begin
                        wr_en     = 1'b1;
                        loaded_in = loaded_ff + CW'(1);
                     end
                  end
                  srtf_pkg::OP_CLEAR: begin
                     loaded_in = '0;
                     fincnt_in = '0;
                     time_in   = '0;
                  end
                  srtf_pkg::OP_TICK: begin
                     rd_idx_in = '0;
                     found_in  = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         srtf_pkg::ST_SCAN: begin
            cmp_vld_in = issue;
            if (issue) begin
               rd_idx_in = rd_idx_ff + CW'(1);
            end
            if (cmp_vld_ff && better) begin
               found_in    = 1'b1;
               best_idx_in = cmp_idx_ff;
               best_arr_in = rd_data.arrival;
               best_bur_in = rd_data.burst;
               best_rem_in = rd_data.remaining;
            end
            if (scan_end) begin
               time_in = time_ff + KW'(1);
            end
         end
         srtf_pkg::ST_DONE: begin
            wr_addr           = best_idx_ff;
            wr_data.arrival   = best_arr_ff;
            wr_data.burst     = best_bur_ff;
            wr_data.remaining = new_rem;
            if (out_free) begin
               wr_en        = found_ff;
               fincnt_in    = fincnt_next;
               rsp_valid_in = 1'b1;
               rsp_in.slot_end_time = time_ff;
               rsp_in.chosen_slot   = found_ff ? srtf_pkg::SLOT_W'(best_idx_ff) : '0;
               rsp_in.idle          = !found_ff;
               rsp_in.finished      = fin;
               rsp_in.turnaround    = fin ? turn : '0;
               rsp_in.waiting       = fin ? (turn - KW'(best_bur_ff)) : '0;
               rsp_in.all_done      = (fincnt_next == loaded_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srtf_pkg::ST_IDLE;
         time_ff      <= '0;
         loaded_ff    <= '0;
         fincnt_ff    <= '0;
         rd_idx_ff    <= '0;
         cmp_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_ff      <= time_in;
         loaded_ff    <= loaded_in;
         fincnt_ff    <= fincnt_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff  <= cmp_idx_in;
      best_idx_ff <= best_idx_in;
      best_arr_ff <= best_arr_in;
      best_bur_ff <= best_bur_in;
      best_rem_ff <= best_rem_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/srtf_process_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// srtf_process_scheduler_unit
// preemptive shortest-remaining-time-first scheduler over a table of processes
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  req       in         req_valid/req_ready   req_item (kind, arrival, burst)
//  rsp       out        rsp_valid/rsp_ready   rsp_item (one per tick item)
//
//  load and clear items are done while the back end is idle and leave it ready
//  a tick holds the back end while it accepts, reads the table once per slot,
//  drains the compare and writes back the chosen entry, if any
//  a two-entry queue between front and back; req_ready drops only when it is full
//  the result register frees the back end as soon as rsp_ready takes the item
//  reset empties the table, the queue and the result register; time is zero
// ----------------------------------------------------------------------------
`default_nettype none

module srtf_process_scheduler_unit #(
   parameter int unsigned MAX_PROCS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire srtf_pkg::req_type req_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output srtf_pkg::rsp_type      rsp_item
);

   logic              cmd_valid;
   logic              cmd_ready;
   srtf_pkg::cmd_type cmd;

   srtf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   srtf_back #(
      .MAX_PROCS (MAX_PROCS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   a_idle_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.idle |-> !rsp_item.finished && (rsp_item.chosen_slot == '0))
      else $error("idle result carries a slot or completion");

   a_unfinished_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.finished |-> (rsp_item.turnaround == '0) &&
                                           (rsp_item.waiting == '0))
      else $error("times reported without completion");

   a_ready_after_reset : assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> req_ready && !rsp_valid)
      else $error("queue or result not empty after reset");

endmodule

`default_nettype wire
